### sv/figure_file_deframer_defines.svh
// Assertion macros shared by the figure file deframer RTL.
// Each macro expects clk and rst in scope; no other dependencies.
`ifndef FIGURE_FILE_DEFRAMER_DEFINES_SVH
`define FIGURE_FILE_DEFRAMER_DEFINES_SVH

// condition must hold at every edge out of reset
`define FDF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define FDF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define FDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/fdf_pkg.sv
// Package for the figure file deframer: payload structs, phase enum, codes.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fdf_pkg;

  // record layout
  localparam int NAME_BYTES = 20;
  localparam int SECT_W     = 6;
  localparam logic [SECT_W-1:0] NAME_LAST = SECT_W'(NAME_BYTES);

  // characteristic byte fields
  localparam int INF_BIT   = 6;
  localparam int TYPE_HI   = 3;
  localparam int TYPE_LO   = 1;

  // polyline header fields
  localparam int COLOR_HI  = 15;
  localparam int COLOR_LO  = 13;
  localparam int PCNT_W    = 10;
  localparam int PBYTES_W  = 13;

  // field kind codes
  localparam logic [2:0] KIND_NAME  = 3'd0;
  localparam logic [2:0] KIND_CHAR  = 3'd1;
  localparam logic [2:0] KIND_COUNT = 3'd2;
  localparam logic [2:0] KIND_HDR   = 3'd3;
  localparam logic [2:0] KIND_POINT = 3'd4;

  // end-of-stream status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_END_HDR  = 2'd1;
  localparam logic [1:0] ST_END_POLY = 2'd2;

  // queue between parser and output stage
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    PH_NAME   = 3'd0,
    PH_CHAR   = 3'd1,
    PH_CNT_LO = 3'd2,
    PH_CNT_HI = 3'd3,
    PH_HDR_LO = 3'd4,
    PH_HDR_HI = 3'd5,
    PH_POINTS = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic [2:0]        field_kind;
    logic [7:0]        byte_value;
    logic [2:0]        figure_type;
    logic              infinite_flag;
    logic [15:0]       polyline_count;
    logic [2:0]        line_color;
    logic [PCNT_W-1:0] point_count;
    logic [PCNT_W-1:0] point_index;
    logic [2:0]        coord_byte;
    logic              polyline_done;
    logic              figure_done;
    logic [1:0]        status;
  } out_t;

  // queue occupancy seen by both sides
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

### sv/fdf_front.sv
// Parser front end: accepts stream bytes, tracks record phase, builds tagged results.
// Depends on fdf_pkg and figure_file_deframer_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "figure_file_deframer_defines.svh"

module fdf_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            src_valid,
  output logic                 src_stall,
  input  wire fdf_pkg::in_t    src_data,
  input  wire fdf_pkg::q_stat_t q_stat,
  output logic                 push,
  output fdf_pkg::out_t        entry
);
  import fdf_pkg::*;

  phase_t              phase, phase_next, phase_adv;
  logic [SECT_W-1:0]   section_count, section_count_next;
  logic [7:0]          held_low_byte, held_low_byte_next;
  logic [15:0]         polylines_left, polylines_left_next;
  logic [PBYTES_W-1:0] point_bytes_left, point_bytes_left_next;
  logic [PCNT_W-1:0]   current_point_count, current_point_count_next;

  logic [7:0]          b;
  logic [15:0]         word;
  logic [15:0]         pl_dec;
  logic                last_pl;
  logic [PCNT_W-1:0]   hdr_pcnt;
  logic [PBYTES_W-1:0] pbl_dec;
  logic [PBYTES_W-1:0] done_bytes;
  logic [SECT_W-1:0]   sect_inc;

  assign b          = src_data.data_byte;
  assign word       = {b, held_low_byte};
  assign pl_dec     = polylines_left - 16'd1;
  assign last_pl    = (pl_dec == 16'd0);
  assign hdr_pcnt   = word[PCNT_W-1:0];
  assign pbl_dec    = point_bytes_left - PBYTES_W'(1);
  assign done_bytes = {current_point_count, 3'b000} - point_bytes_left;
  assign sect_inc   = section_count + SECT_W'(1);

  assign src_stall = q_stat.full;
  assign push      = src_valid && !q_stat.full;

  // next phase
  always_comb begin
    case (phase)
      PH_CHAR:   phase_adv = PH_CNT_LO;
      PH_CNT_LO: phase_adv = PH_CNT_HI;
      PH_CNT_HI: phase_adv = (word == 16'd0) ? PH_NAME : PH_HDR_LO;
      PH_HDR_LO: phase_adv = PH_HDR_HI;
      PH_HDR_HI: begin
        if (hdr_pcnt == '0) phase_adv = last_pl ? PH_NAME : PH_HDR_LO;
        else                phase_adv = PH_POINTS;
      end
      PH_POINTS: begin
        if (pbl_dec == '0) phase_adv = last_pl ? PH_NAME : PH_HDR_LO;
        else               phase_adv = PH_POINTS;
      end
      default:   phase_adv = (sect_inc >= NAME_LAST) ? PH_CHAR : PH_NAME;
    endcase
    phase_next = src_data.stream_end ? PH_NAME : phase_adv;
  end

  // result fields and datapath registers
  always_comb begin
    entry                    = '0;
    entry.byte_value         = b;
    section_count_next       = section_count;
    held_low_byte_next       = held_low_byte;
    polylines_left_next      = polylines_left;
    point_bytes_left_next    = point_bytes_left;
    current_point_count_next = current_point_count;
    case (phase)
      PH_CHAR: begin
        entry.field_kind    = KIND_CHAR;
        entry.figure_type   = b[TYPE_HI:TYPE_LO];
        entry.infinite_flag = b[INF_BIT];
      end
      PH_CNT_LO: begin
        entry.field_kind   = KIND_COUNT;
        held_low_byte_next = b;
      end
      PH_CNT_HI: begin
        entry.field_kind     = KIND_COUNT;
        entry.polyline_count = word;
        if (word == 16'd0) entry.figure_done = 1'b1;
        else               polylines_left_next = word;
      end
      PH_HDR_LO: begin
        entry.field_kind   = KIND_HDR;
        held_low_byte_next = b;
      end
      PH_HDR_HI: begin
        entry.field_kind         = KIND_HDR;
        entry.line_color         = word[COLOR_HI:COLOR_LO];
        entry.point_count        = hdr_pcnt;
        current_point_count_next = hdr_pcnt;
        if (hdr_pcnt == '0) begin
          entry.polyline_done = 1'b1;
          entry.figure_done   = last_pl;
          polylines_left_next = pl_dec;
        end else begin
          point_bytes_left_next = {hdr_pcnt, 3'b000};
        end
      end
      PH_POINTS: begin
        entry.field_kind      = KIND_POINT;
        entry.point_index     = done_bytes[PBYTES_W-1:3];
        entry.coord_byte      = done_bytes[2:0];
        point_bytes_left_next = pbl_dec;
        if (pbl_dec == '0) begin
          entry.polyline_done = 1'b1;
          entry.figure_done   = last_pl;
          polylines_left_next = pl_dec;
        end
      end
      default: begin
        entry.field_kind   = KIND_NAME;
        section_count_next = (sect_inc >= NAME_LAST) ? '0 : sect_inc;
      end
    endcase

    if (src_data.stream_end) begin
      if (entry.figure_done) begin
        entry.status = ST_OK;
      end else if (phase_adv inside {PH_HDR_LO, PH_HDR_HI, PH_POINTS}) begin
        entry.status = ST_END_POLY;
      end else begin
        entry.status = ST_END_HDR;
      end
      section_count_next       = '0;
      held_low_byte_next       = '0;
      polylines_left_next      = '0;
      point_bytes_left_next    = '0;
      current_point_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_NAME;
      section_count       <= '0;
      held_low_byte       <= '0;
      polylines_left      <= '0;
      point_bytes_left    <= '0;
      current_point_count <= '0;
    end else if (push) begin
      phase               <= phase_next;
      section_count       <= section_count_next;
      held_low_byte       <= held_low_byte_next;
      polylines_left      <= polylines_left_next;
      point_bytes_left    <= point_bytes_left_next;
      current_point_count <= current_point_count_next;
    end
  end

  `FDF_ASSERT_SAME(a_status_only_at_end, push && (entry.status != ST_OK), src_data.stream_end, "status set without stream end")
  `FDF_ASSERT_NEXT(a_end_restarts, push && src_data.stream_end, (phase == PH_NAME) && (section_count == '0) && (polylines_left == 16'd0), "state not cleared after stream end")
  `FDF_ASSERT_NEXT(a_figure_done_to_name, push && entry.figure_done, phase == PH_NAME, "figure end did not return to name phase")
  `FDF_ASSERT_SAME(a_poly_done_kind, push && entry.polyline_done, (entry.field_kind == KIND_HDR) || (entry.field_kind == KIND_POINT), "polyline end on wrong field kind")

endmodule

`default_nettype wire

### sv/fdf_queue.sv
// Two-entry queue of tagged results between the parser and the output stage.
// Depends on fdf_pkg and figure_file_deframer_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "figure_file_deframer_defines.svh"

module fdf_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire fdf_pkg::out_t    wr_data,
  input  wire logic             pop,
  output fdf_pkg::out_t         rd_data,
  output fdf_pkg::q_stat_t      q_stat
);
  import fdf_pkg::*;

  out_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign rd_data          = slots[rd_ptr];
  assign q_stat.not_empty = (count != '0);
  assign q_stat.full      = (count == QCNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `FDF_ASSERT_ALWAYS(a_count_bound, count <= QCNT_W'(QDEPTH), "queue count beyond depth")
  `FDF_ASSERT_SAME(a_no_overflow, push, !q_stat.full || pop, "push into full queue")
  `FDF_ASSERT_SAME(a_no_underflow, pop, q_stat.not_empty, "pop from empty queue")
  `FDF_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + QCNT_W'(1), "count did not advance on push")

endmodule

`default_nettype wire

### sv/fdf_back.sv
// Output stage: drains the result queue into the registered result channel.
// Depends on fdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdf_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fdf_pkg::q_stat_t q_stat,
  input  wire fdf_pkg::out_t    q_data,
  output logic                  pop,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output fdf_pkg::out_t         res_data
);
  import fdf_pkg::*;

  // load when the register is empty or its transfer completes this cycle
  assign pop = q_stat.not_empty && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      res_valid <= q_stat.not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) res_data <= q_data;
  end

endmodule

`default_nettype wire

### sv/figure_file_deframer.sv
// Figure file deframer, top level; uses fdf_pkg, fdf_front, fdf_queue, fdf_back.
// Takes one stream byte per transfer and returns one tagged result per byte. Each
// record is NAME_BYTES name bytes, a characteristic byte, a little-endian polyline
// count, then per polyline a 16-bit header and eight bytes per point. Results
// carry the field kind, the byte itself, decoded header fields, the point and
// coordinate position of point bytes, and polyline/figure end flags. On the byte
// marked stream_end, status tells whether the stream stopped cleanly, inside a
// figure header, or inside polyline data; the parser then restarts at a name.
// Rate: one byte per clock while res_stall stays low. The parser's phase register
// updates every accepted byte, and a two-entry queue plus the output register let
// it keep taking bytes while a result waits. A byte's result enters the queue
// when the byte is taken and moves into the output register once that register
// is empty or its transfer completes; src_stall rises only when the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module figure_file_deframer (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          src_valid,
  output logic               src_stall,
  input  wire fdf_pkg::in_t  src_data,
  output logic               res_valid,
  input  wire logic          res_stall,
  output fdf_pkg::out_t      res_data
);
  import fdf_pkg::*;

  q_stat_t q_stat;
  out_t    entry;
  out_t    q_data;
  logic    push;
  logic    pop;

  // parser: record phase tracking and tagging
  fdf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .q_stat    (q_stat),
    .push      (push),
    .entry     (entry)
  );

  // decouples parser from output backpressure
  fdf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (entry),
    .pop     (pop),
    .rd_data (q_data),
    .q_stat  (q_stat)
  );

  // registered result channel
  fdf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_data    (q_data),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

`default_nettype wire
